// ===== hdl/mfom_pkg.sv =====
// Shared types and constants of the message FIFO overload monitor.
`default_nettype none

package mfom_pkg;

   localparam int MSG_PORT_W = 64;
   localparam int LEN_W      = 12;
   localparam int BASE_W     = 12;
   localparam int MIN_THR_W  = 13;

   localparam logic [BASE_W-1:0] BASE_RESET = 12'd1024;

   typedef enum logic [1:0] {
      OP_PUSH     = 2'd0,
      OP_POP      = 2'd1,
      OP_READ_OVL = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

`default_nettype wire

// ===== hdl/mfom_channels.sv =====
// Request and response channel interfaces of the message FIFO overload monitor.
`default_nettype none

interface mfom_req_if;
   import mfom_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [1:0]            op;
   logic [MSG_PORT_W-1:0] msg_data;

   modport source (output valid, output op, output msg_data, input ready);
   modport sink   (input valid, input op, input msg_data, output ready);
endinterface

interface mfom_rsp_if;
   import mfom_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic [MSG_PORT_W-1:0] msg_out;
   logic                  schedule;
   logic [LEN_W-1:0]      length;
   logic [LEN_W-1:0]      overload_value;

   modport source (output valid, output status, output msg_out, output schedule,
                   output length, output overload_value, input ready);
   modport sink   (input valid, input status, input msg_out, input schedule,
                   input length, input overload_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/message_fifo_overload_monitor_unit.sv =====
// Top level of the message FIFO overload monitor: ring memory, pointers and threshold logic.
`default_nettype none

//  Channel    Direction  Handshake      Payload
//  req_if     in         valid/ready    op, msg_data
//  rsp_if     out        valid/ready    status, msg_out, schedule, length, overload_value
//  csr_*      in         csr_wr_en      csr_wr_data (overload base, 12 bits)
//
//  In the accept cycle of an item the ring memory is written (push) or read at the head
//  (pop) and all pointer, count and threshold updates are made; in the S_DONE state
//  that follows, the registered memory read data is merged into the response.
//  Reset is synchronous: it clears pointers, count and overload value, sets the
//  schedule flag and loads the threshold and base with BASE_RESET; the ring memory
//  itself is not cleared, since a pop only reads entries that a push has written.
//  A response that is not taken still lets one more item in; that item then waits in
//  S_DONE, and no further item is accepted until the response register can be loaded.

module message_fifo_overload_monitor_unit #(
   parameter int CAPACITY  = 4096,
   parameter int MSG_WIDTH = 64
) (
   input  wire                          clock,
   input  wire                          reset,
   mfom_req_if.sink                     req_if,
   mfom_rsp_if.source                   rsp_if,
   input  wire                          csr_wr_en,
   input  wire [mfom_pkg::BASE_W-1:0]   csr_wr_data
);
   import mfom_pkg::*;

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int THR_W = (PTR_W + 1 > MIN_THR_W) ? PTR_W + 1 : MIN_THR_W;
   localparam int CMP_W = THR_W + PTR_W + 1;
   localparam int EXT_W = (PTR_W > LEN_W) ? PTR_W : LEN_W;
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(CAPACITY - 1);

   typedef enum logic {
      S_IDLE,
      S_DONE
   } state_type;

   // Ring memory, one synchronous port.
   logic [MSG_WIDTH-1:0] ring_mem [CAPACITY];
   logic [MSG_WIDTH-1:0] rd_data_ff;

   state_type            state_ff;
   logic [PTR_W-1:0]     head_ff, head_in;
   logic [PTR_W-1:0]     tail_ff, tail_in;
   logic [PTR_W-1:0]     count_ff, count_in;
   logic                 sched_ff, sched_in;
   logic [LEN_W-1:0]     ovl_ff, ovl_in;
   logic [THR_W-1:0]     thr_ff, thr_in;
   logic [BASE_W-1:0]    base_ff;

   // Fields of the item in flight, settled in the accept cycle.
   status_type           pend_status_ff, pend_status_in;
   logic                 pend_sched_ff, pend_sched_in;
   logic                 pend_pop_ff, pend_pop_in;
   logic [LEN_W-1:0]     pend_len_ff, pend_len_in;
   logic [LEN_W-1:0]     pend_ovl_ff, pend_ovl_in;

   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [MSG_PORT_W-1:0] rsp_msg_ff;
   logic                 rsp_sched_ff;
   logic [LEN_W-1:0]     rsp_len_ff;
   logic [LEN_W-1:0]     rsp_ovl_ff;

   logic                 req_fire;
   logic                 push_wr;
   logic                 rsp_free;
   logic [PTR_W-1:0]     pop_len;
   logic [CMP_W-1:0]     pop_len_cmp;
   logic [CMP_W-1:0]     cand;
   logic [THR_W-1:0]     thr_grown;
   logic                 thr_found;
   logic [EXT_W-1:0]     len_ext;

   assign req_fire     = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == S_IDLE);
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = rsp_status_ff;
   assign rsp_if.msg_out        = rsp_msg_ff;
   assign rsp_if.schedule       = rsp_sched_ff;
   assign rsp_if.length         = rsp_len_ff;
   assign rsp_if.overload_value = rsp_ovl_ff;

   // Length left after a pop, and the threshold doubled until it reaches that length.
   // Every candidate shift is compared in parallel; the smallest one that fits wins.
   assign pop_len     = count_ff - PTR_W'(1);
   assign pop_len_cmp = CMP_W'(pop_len);

   always_comb begin
      thr_grown = thr_ff;
      thr_found = 1'b0;
      cand      = '0;
      for (int k = 0; k <= PTR_W; k++) begin
         cand = CMP_W'(thr_ff) << k;
         if (!thr_found && cand >= pop_len_cmp) begin
            thr_grown = THR_W'(cand);
            thr_found = 1'b1;
         end
      end
   end

   // State updates for the accepted item.
   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      sched_in       = sched_ff;
      ovl_in         = ovl_ff;
      thr_in         = thr_ff;
      push_wr        = 1'b0;
      pend_status_in = ST_OK;
      pend_sched_in  = 1'b0;
      pend_pop_in    = 1'b0;
      pend_ovl_in    = '0;
      if (req_fire) begin
         case (req_if.op)
            OP_PUSH: begin
               if (count_ff == LAST_IDX) begin
                  pend_status_in = ST_FULL;
               end else begin
                  push_wr  = 1'b1;
                  tail_in  = (tail_ff == LAST_IDX) ? '0 : tail_ff + PTR_W'(1);
                  count_in = count_ff + PTR_W'(1);
                  if (!sched_ff) begin
                     sched_in      = 1'b1;
                     pend_sched_in = 1'b1;
                  end
               end
            end
            OP_POP: begin
               if (count_ff != '0) begin
                  pend_pop_in = 1'b1;
                  head_in     = (head_ff == LAST_IDX) ? '0 : head_ff + PTR_W'(1);
                  count_in    = pop_len;
                  if (pop_len_cmp > CMP_W'(thr_ff)) begin
                     len_ext = EXT_W'(pop_len);
                     ovl_in  = len_ext[LEN_W-1:0];
                     thr_in  = thr_grown;
                  end
               end else begin
                  pend_status_in = ST_EMPTY;
                  thr_in         = THR_W'(base_ff);
                  sched_in       = 1'b0;
               end
            end
            OP_READ_OVL: begin
               pend_ovl_in = ovl_ff;
               ovl_in      = '0;
            end
            default: begin
            end
         endcase
      end
      len_ext     = EXT_W'(count_in);
      pend_len_in = len_ext[LEN_W-1:0];
   end

   // Ring memory: write at the tail on a push, read at the head on any other accept.
   always_ff @(posedge clock) begin
      if (push_wr) begin
         ring_mem[tail_ff] <= req_if.msg_data[MSG_WIDTH-1:0];
      end else if (req_fire) begin
         rd_data_ff <= ring_mem[head_ff];
      end
   end

   // Overload base register; a zero write is stored as one so the doubling ends.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
      end else if (csr_wr_en) begin
         base_ff <= (csr_wr_data == '0) ? BASE_W'(1) : csr_wr_data;
      end
   end

   // Pointers, flags and threshold.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         sched_ff <= 1'b1;
         ovl_ff   <= '0;
         thr_ff   <= THR_W'(BASE_RESET);
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         sched_ff <= sched_in;
         ovl_ff   <= ovl_in;
         thr_ff   <= thr_in;
      end
   end

   // Sequencer and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (rsp_if.ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (req_fire) begin
                  state_ff       <= S_DONE;
                  pend_status_ff <= pend_status_in;
                  pend_sched_ff  <= pend_sched_in;
                  pend_pop_ff    <= pend_pop_in;
                  pend_len_ff    <= pend_len_in;
                  pend_ovl_ff    <= pend_ovl_in;
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  state_ff      <= S_IDLE;
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= pend_status_ff;
                  rsp_msg_ff    <= pend_pop_ff ? MSG_PORT_W'(rd_data_ff) : '0;
                  rsp_sched_ff  <= pend_sched_ff;
                  rsp_len_ff    <= pend_len_ff;
                  rsp_ovl_ff    <= pend_ovl_ff;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== hdl/mfom_checker.sv =====
// Port-level checker of the message FIFO overload monitor and its bind statement.
`default_nettype none

module mfom_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_valid,
   input wire                              req_ready,
   input wire                              rsp_valid,
   input wire                              rsp_ready,
   input wire [1:0]                        rsp_status,
   input wire [mfom_pkg::MSG_PORT_W-1:0]   rsp_msg_out,
   input wire                              rsp_schedule,
   input wire [mfom_pkg::LEN_W-1:0]        rsp_length,
   input wire [mfom_pkg::LEN_W-1:0]        rsp_overload_value
);
   import mfom_pkg::*;

   // A stalled response holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_msg_out)
         && $stable(rsp_length) && $stable(rsp_overload_value))
      else $error("stalled response changed");

   // One item at a time: ready drops right after an accept.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in flight");

   // An empty pop leaves nothing and returns no word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_length == '0 && rsp_msg_out == '0
         && !rsp_schedule)
      else $error("empty pop reported a word or a length");

   // Scheduling and overload readout come only with a good status and no popped word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_schedule || rsp_overload_value != '0) |-> rsp_status == ST_OK
         && rsp_msg_out == '0)
      else $error("schedule or overload value on a wrong response");

endmodule

bind message_fifo_overload_monitor_unit mfom_checker u_mfom_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_if.valid),
   .req_ready          (req_if.ready),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_status         (rsp_if.status),
   .rsp_msg_out        (rsp_if.msg_out),
   .rsp_schedule       (rsp_if.schedule),
   .rsp_length         (rsp_if.length),
   .rsp_overload_value (rsp_if.overload_value)
);

`default_nettype wire
